// ===== design/assert_macros.svh =====
// Assertion macros for the box blur RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define BBC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition in one cycle that forces another in the next cycle.
`define BBC_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define BBC_ASSERT(label, clk, rst, prop, msg)
`define BBC_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

// ===== design/bbc_pkg.sv =====
// Shared types, constants and the reciprocal table of the box blur.
`timescale 1ns / 1ps
package bbc_pkg;

  localparam int MAX_COLS_DEF   = 1024;
  localparam int FRAME_WIDTH_W  = 11;
  localparam int FRAME_HEIGHT_W = 16;
  localparam int PIX_W          = 8;
  localparam int CFG_INDEX_W    = 2;
  localparam int SUM_W          = 12;
  localparam int RECIP_W        = 17;
  localparam int RECIP_SHIFT    = 16;

  localparam logic [FRAME_WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [FRAME_HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;

  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = 2'd1;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // One window column, older row first.
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } col_t;

  // Which neighbours of the centre pixel lie inside the frame.
  typedef struct packed {
    logic has_top;
    logic has_bottom;
    logic has_left;
    logic has_right;
  } edge_t;

  // ceil(2^16 / count); exact floor division for any sum below 2^15.
  function automatic logic [RECIP_W-1:0] recip(input logic [1:0] rows,
                                              input logic [1:0] cols);
    logic [3:0] cnt;
    cnt = 4'(rows) * 4'(cols);
    unique case (cnt)
      4'd2:    recip = 17'd32768;
      4'd3:    recip = 17'd21846;
      4'd4:    recip = 17'd16384;
      4'd6:    recip = 17'd10923;
      4'd9:    recip = 17'd7282;
      default: recip = 17'd65536;
    endcase
  endfunction

endpackage

// ===== design/bbc_mean.sv =====
// Neighbourhood sum and count, followed by a reciprocal multiply for the mean.
`timescale 1ns / 1ps
module bbc_mean (
  input  logic                        clk,
  input  logic                        load,
  input  bbc_pkg::col_t               left,
  input  bbc_pkg::col_t               centre,
  input  bbc_pkg::col_t               right,
  input  bbc_pkg::edge_t              edges,
  output logic [bbc_pkg::PIX_W-1:0]   mean
);

  localparam int ProdW = bbc_pkg::SUM_W + bbc_pkg::RECIP_W;

  logic [bbc_pkg::SUM_W-1:0]   sum;
  logic [1:0]                  rows;
  logic [1:0]                  cols;
  logic [bbc_pkg::SUM_W-1:0]   sum_q;
  logic [bbc_pkg::RECIP_W-1:0] recip_q;
  logic [ProdW-1:0]            prod;

  function automatic logic [bbc_pkg::SUM_W-1:0] col_sum(input bbc_pkg::col_t c,
                                                        input bbc_pkg::edge_t e);
    logic [bbc_pkg::SUM_W-1:0] s;
    s = bbc_pkg::SUM_W'(c.mid);
    if (e.has_top) s = s + bbc_pkg::SUM_W'(c.top);
    if (e.has_bottom) s = s + bbc_pkg::SUM_W'(c.bot);
    return s;
  endfunction

  always_comb begin
    sum = col_sum(centre, edges);
    if (edges.has_left) sum = sum + col_sum(left, edges);
    if (edges.has_right) sum = sum + col_sum(right, edges);
    rows = 2'd1 + 2'(edges.has_top) + 2'(edges.has_bottom);
    cols = 2'd1 + 2'(edges.has_left) + 2'(edges.has_right);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum_q   <= sum;
      recip_q <= bbc_pkg::recip(rows, cols);
    end
  end

  assign prod = ProdW'(sum_q) * ProdW'(recip_q);
  assign mean = prod[bbc_pkg::RECIP_SHIFT +: bbc_pkg::PIX_W];

endmodule

// ===== design/box_blur_3x3_clipped.sv =====
// Top level of the clipped 3x3 box blur with its line store and control.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata = pixel, s_tuser = action (1 = flush)
//  m_      | out | m_tvalid/m_tready  | m_tdata = blurred, m_tlast = frame_end
//  cfg_    | in  | cfg_wen            | cfg_index (0 width, 1 height), cfg_data
//
// A pixel passes through the line-store read and then the window update and write back;
// one that gives a result then passes through the divide stage as well.
// A flush runs one or two padding arrivals back to back (the control allows three);
// a dropped transfer leaves the state and positions unchanged.
// Reset is synchronous; the line store is not cleared, since unwritten columns only
// reach window positions that the edge clipping leaves out.
// A result waiting at the output holds the divide stage until it is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module box_blur_3x3_clipped #(
  parameter int MAX_COLS = bbc_pkg::MAX_COLS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [bbc_pkg::PIX_W-1:0]           s_tdata,   // [7:0] pixel
  input  logic                                s_tuser,   // [0] action
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [bbc_pkg::PIX_W-1:0]           m_tdata,   // [7:0] blurred
  output logic                                m_tlast,
  input  logic                                cfg_wen,
  input  logic [bbc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bbc_pkg::FRAME_HEIGHT_W-1:0]  cfg_data
);

  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int WW = $clog2(MAX_COLS + 1);
  localparam int AW = WW + 1;
  localparam int FW = bbc_pkg::FRAME_WIDTH_W;
  localparam int HW = bbc_pkg::FRAME_HEIGHT_W;
  localparam int EW = (FW > WW) ? FW : WW;
  localparam int RW = HW + 1;

  typedef enum logic [1:0] {IDLE, ARRIVE, DIV} state_t;

  state_t                    state;
  logic [FW-1:0]             frame_width;
  logic [HW-1:0]             frame_height;
  logic [CW-1:0]             in_column;
  logic [RW-1:0]             in_row;
  logic [CW-1:0]             out_column;
  logic [HW-1:0]             out_row;
  logic [AW-1:0]             lag;
  logic                      draining;
  logic                      flushing;
  logic [1:0]                tries;
  logic [bbc_pkg::PIX_W-1:0] pix_reg;
  logic                      last_reg;
  bbc_pkg::col_t             win_old;
  bbc_pkg::col_t             win_new;

  logic [15:0]               line_mem [MAX_COLS];
  logic [15:0]               mem_q;
  logic                      fwd_hit;
  logic [15:0]               fwd_data;
  logic [15:0]               rd_data;
  logic [15:0]               wr_data;
  logic                      mem_re;
  logic                      mem_we;
  logic [CW-1:0]             rd_addr;

  logic [EW-1:0]             fw_ext;
  logic [WW-1:0]             eff_w;
  logic [HW-1:0]             eff_h;
  logic                      accept;
  logic                      go;
  logic                      emit;
  logic                      retry;
  logic                      col_wrap;
  logic [CW-1:0]             in_column_next;
  logic                      last_in;
  logic                      q_col_last;
  logic                      q_row_last;
  logic                      cfg_hit;
  logic                      restart;
  bbc_pkg::col_t             incoming;
  bbc_pkg::edge_t            edges;
  logic [bbc_pkg::PIX_W-1:0] mean;

  always_comb begin
    fw_ext = EW'(frame_width);
    if (fw_ext == '0) begin
      eff_w = WW'(1);
    end else if (fw_ext > EW'(MAX_COLS)) begin
      eff_w = WW'(MAX_COLS);
    end else begin
      eff_w = WW'(fw_ext);
    end
    eff_h = (frame_height == '0) ? HW'(1) : frame_height;
  end

  assign s_tready = (state == IDLE);
  assign accept   = s_tvalid && s_tready;
  assign go       = (s_tuser == bbc_pkg::ACT_PIXEL && !draining) ||
                    (s_tuser == bbc_pkg::ACT_FLUSH && draining);
  assign cfg_hit  = cfg_wen && (cfg_index == bbc_pkg::REG_WIDTH ||
                                cfg_index == bbc_pkg::REG_HEIGHT);

  // Positions of the next arrival and of the next result.
  assign col_wrap       = (AW'(in_column) + AW'(1)) >= AW'(eff_w);
  assign in_column_next = col_wrap ? '0 : in_column + CW'(1);
  assign last_in        = ((RW + 1)'(in_row) + (RW + 1)'(1)) >= (RW + 1)'(eff_h) && col_wrap;
  assign q_col_last     = (AW'(out_column) + AW'(1)) >= AW'(eff_w);
  assign q_row_last     = (RW'(out_row) + RW'(1)) >= RW'(eff_h);
  // The result trails the arrivals by one row and one column.
  assign emit           = (lag == AW'(eff_w) + AW'(1));
  assign retry          = !emit && flushing && (tries != 2'd2);
  assign restart        = cfg_hit || (state == ARRIVE && emit && q_row_last && q_col_last);

  // Line store: older row in the high byte, newer row in the low byte.
  assign rd_data  = fwd_hit ? fwd_data : mem_q;
  assign incoming = '{top: rd_data[15:8], mid: rd_data[7:0], bot: pix_reg};
  assign wr_data  = {rd_data[7:0], pix_reg};
  assign mem_we   = (state == ARRIVE);
  assign mem_re   = (accept && go) || (state == ARRIVE && retry);
  assign rd_addr  = (state == IDLE) ? in_column : in_column_next;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[in_column] <= wr_data;
    end
    if (mem_re) begin
      mem_q <= line_mem[rd_addr];
    end
  end

  // A read of the column being written in the same cycle takes the new word.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= mem_re && mem_we && (rd_addr == in_column);
    end
    fwd_data <= wr_data;
  end

  assign edges = '{has_top:    (out_row != '0),
                   has_bottom: !q_row_last,
                   has_left:   (out_column != '0),
                   has_right:  !q_col_last};

  bbc_mean u_mean (
    .clk    (clk),
    .load   (state == ARRIVE && emit),
    .left   (win_old),
    .centre (win_new),
    .right  (incoming),
    .edges  (edges),
    .mean   (mean)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      frame_width  <= bbc_pkg::WIDTH_RESET;
      frame_height <= bbc_pkg::HEIGHT_RESET;
      in_column    <= '0;
      in_row       <= '0;
      out_column   <= '0;
      out_row      <= '0;
      lag          <= '0;
      draining     <= 1'b0;
      flushing     <= 1'b0;
      tries        <= '0;
      pix_reg      <= '0;
      last_reg     <= 1'b0;
      win_old      <= '0;
      win_new      <= '0;
      m_tvalid     <= 1'b0;
      m_tdata      <= '0;
      m_tlast      <= 1'b0;
    end else begin
      // The divide stage refills the output register in the cycle it empties.
      if (m_tvalid && m_tready && state != DIV) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept && go) begin
            flushing <= (s_tuser == bbc_pkg::ACT_FLUSH);
            pix_reg  <= (s_tuser == bbc_pkg::ACT_FLUSH) ? '0 : s_tdata;
            tries    <= '0;
            state    <= ARRIVE;
          end
        end
        ARRIVE: begin
          win_old <= win_new;
          win_new <= incoming;
          tries   <= tries + 2'd1;
          if (emit) begin
            last_reg <= q_row_last && q_col_last;
            state    <= DIV;
          end else if (!retry) begin
            state <= IDLE;
          end
        end
        DIV: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= mean;
            m_tlast  <= last_reg;
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
      // A write to the width or height register abandons the frame in progress.
      if (cfg_hit) begin
        if (cfg_index == bbc_pkg::REG_WIDTH) begin
          frame_width <= cfg_data[FW-1:0];
        end else begin
          frame_height <= cfg_data;
        end
      end
      // The last result of a frame also returns every position to zero.
      if (restart) begin
        in_column  <= '0;
        in_row     <= '0;
        out_column <= '0;
        out_row    <= '0;
        lag        <= '0;
        draining   <= 1'b0;
      end else if (state == ARRIVE) begin
        in_column <= in_column_next;
        if (col_wrap) begin
          in_row <= in_row + RW'(1);
        end
        if (!emit) begin
          lag <= lag + AW'(1);
        end
        if (!flushing && last_in) begin
          draining <= 1'b1;
        end
        if (emit) begin
          if (q_col_last) begin
            out_column <= '0;
            out_row    <= out_row + HW'(1);
          end else begin
            out_column <= out_column + CW'(1);
          end
        end
      end
    end
  end

  `BBC_ASSERT(a_lag_bound, clk, rst, lag <= AW'(eff_w) + AW'(1), "arrival lead beyond one row")
  `BBC_ASSERT(a_out_col_range, clk, rst, AW'(out_column) < AW'(eff_w), "result column out of range")
  `BBC_ASSERT(a_flush_bound, clk, rst, !(state == ARRIVE && tries == 2'd3), "flush ran too long")
  `BBC_ASSERT_NEXT(a_result_load, clk, rst, state == DIV && (!m_tvalid || m_tready), m_tvalid && state == IDLE, "result not loaded")
  `BBC_ASSERT_NEXT(a_drop, clk, rst, accept && !go && !cfg_wen, state == IDLE && $stable(in_column), "dropped transfer moved state")

endmodule

// ===== tb/box_blur_3x3_clipped_test.sv =====
// Self-checking stream testbench for the clipped 3x3 box blur.
`timescale 1ns / 1ps
module box_blur_3x3_clipped_test;
  import bbc_pkg::*;

  localparam int LINE_COLS = MAX_COLS_DEF;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int IDLE_PCT = 27;

  typedef struct {
    logic             action;
    logic [PIX_W-1:0] pixel;
  } feed_t;

  typedef struct {
    logic [PIX_W-1:0] blurred;
    logic             frame_end;
  } blur_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [PIX_W-1:0]          s_tdata = '0;    // [7:0] pixel
  logic                      s_tuser = 1'b0;  // [0] action
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [PIX_W-1:0]          m_tdata;         // [7:0] blurred
  logic                      m_tlast;
  logic                      cfg_wen = 1'b0;
  logic [CFG_INDEX_W-1:0]    cfg_index = '0;
  logic [FRAME_HEIGHT_W-1:0] cfg_data = '0;

  // Items waiting for the driver, and blurred pixels still owed by the block.
  feed_t pixel_feed[$];
  feed_t nxt;
  blur_t blur_due[$];
  blur_t want;

  // Predictor state.
  logic [FRAME_WIDTH_W-1:0]  reg_w;
  logic [FRAME_HEIGHT_W-1:0] reg_h;
  logic [15:0]               lines [LINE_COLS];
  logic [PIX_W-1:0]          win [9];
  int unsigned               in_col, in_row, out_col, out_row;
  bit                        draining;

  // Stimulus bookkeeping.
  logic [FRAME_WIDTH_W-1:0]  gen_w = WIDTH_RESET;
  logic [FRAME_HEIGHT_W-1:0] gen_h = HEIGHT_RESET;
  int unsigned               sent = 0;
  bit                        steady = 1'b0;
  int                        mismatches = 0;
  int                        quiet_cycles = 0;

  box_blur_3x3_clipped dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int unsigned eff_cols(input logic [FRAME_WIDTH_W-1:0] w);
    if (w == 0) return 1;
    if (w > LINE_COLS) return LINE_COLS;
    return w;
  endfunction

  function automatic int unsigned eff_rows(input logic [FRAME_HEIGHT_W-1:0] h);
    return (h == 0) ? 1 : h;
  endfunction

  function automatic void restart_frame();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    draining = 1'b0;
  endfunction

  function automatic void clear_prediction();
    int i;
    reg_w = WIDTH_RESET;
    reg_h = HEIGHT_RESET;
    for (i = 0; i < LINE_COLS; i++) lines[i] = '0;
    for (i = 0; i < 9; i++) win[i] = '0;
    restart_frame();
  endfunction

  function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [FRAME_HEIGHT_W-1:0] val);
    if (idx == REG_WIDTH) begin
      reg_w = val[FRAME_WIDTH_W-1:0];
      restart_frame();
    end else if (idx == REG_HEIGHT) begin
      reg_h = val;
      restart_frame();
    end
  endfunction

  // Shifts one pixel (real or padding) into the window; returns 1 when it
  // completes the neighbourhood of the oldest pixel still owed.
  function automatic bit shift_in(input logic [PIX_W-1:0] pix, output blur_t res);
    int unsigned w, h, c, qi, qj, cc, sum, cnt;
    logic [15:0] entry;
    logic [PIX_W-1:0] prev [9];
    longint unsigned p, q;
    int dr, dc, col, i;
    bit last;
    w = eff_cols(reg_w);
    h = eff_rows(reg_h);
    res.blurred = '0;
    res.frame_end = 1'b0;
    c = (in_col < LINE_COLS) ? in_col : 0;
    entry = lines[c];
    lines[c] = {entry[7:0], pix};
    prev = win;
    for (i = 0; i < 6; i++) win[i] = win[i + 3];
    win[6] = entry[15:8];
    win[7] = entry[7:0];
    win[8] = pix;
    qi = out_row;
    qj = out_col;
    p = 64'(in_row) * w + c;
    q = 64'(qi) * w + qj;
    if (c + 1 >= w) begin
      in_col = 0;
      in_row++;
    end else begin
      in_col = c + 1;
    end
    if (p != q + w + 1) return 0;
    // At the start of a row the centre sits in the last column of the old window.
    cc = (c == 0) ? 2 : 1;
    sum = 0;
    cnt = 0;
    for (dr = -1; dr <= 1; dr++) begin
      if ((dr < 0 && qi == 0) || (dr > 0 && qi + 1 >= h)) continue;
      for (dc = -1; dc <= 1; dc++) begin
        if ((dc < 0 && qj == 0) || (dc > 0 && qj + 1 >= w)) continue;
        col = int'(cc) + dc;
        if (col > 2) continue;
        sum += (c == 0) ? prev[col * 3 + 1 + dr] : win[col * 3 + 1 + dr];
        cnt++;
      end
    end
    if (cnt == 0) cnt = 1;
    last = (qi + 1 >= h) && (qj + 1 >= w);
    res.blurred = 8'(sum / cnt);
    res.frame_end = last;
    if (last) begin
      restart_frame();
    end else if (qj + 1 >= w) begin
      out_col = 0;
      out_row = qi + 1;
    end else begin
      out_col = qj + 1;
    end
    return 1;
  endfunction

  function automatic void predict_blur(input logic act, input logic [PIX_W-1:0] pix);
    bit last_in;
    blur_t res;
    int k;
    if (act == ACT_PIXEL) begin
      if (!draining) begin
        last_in = (in_row + 1 >= eff_rows(reg_h)) && (in_col + 1 >= eff_cols(reg_w));
        if (shift_in(pix, res)) blur_due.push_back(res);
        if (last_in) draining = 1'b1;
      end
    end else if (draining) begin
      // A flush pads with zero pixels until one result falls out.
      for (k = 0; k < 3; k++) begin
        if (shift_in('0, res)) begin
          blur_due.push_back(res);
          break;
        end
      end
    end
  endfunction

  function automatic logic [PIX_W-1:0] rand_pix();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_item(input logic act, input logic [PIX_W-1:0] pix);
    feed_t it;
    it.action = act;
    it.pixel = pix;
    pixel_feed.push_back(it);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [FRAME_HEIGHT_W-1:0] val);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_WIDTH) gen_w = val[FRAME_WIDTH_W-1:0];
    else if (idx == REG_HEIGHT) gen_h = val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  // Waits until every transfer is done and the block has had time to finish.
  task automatic settle();
    do @(negedge clk);
    while (pixel_feed.size() != 0 || s_tvalid || blur_due.size() != 0);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  // Sends npix pixels of the current frame; a whole frame is followed by its drain.
  task automatic feed_frame(input int unsigned npix);
    int unsigned w, total, drain, i;
    w = eff_cols(gen_w);
    total = w * eff_rows(gen_h);
    drain = (total < w + 1) ? total : w + 1;
    for (i = 0; i < npix; i++) begin
      if ($urandom_range(0, 9) == 0) push_item(ACT_FLUSH, rand_pix());
      push_item(ACT_PIXEL, rand_pix());
      sent++;
    end
    if (npix == total) begin
      for (i = 0; i < drain; i++) begin
        if ($urandom_range(0, 9) == 0) push_item(ACT_PIXEL, rand_pix());
        push_item(ACT_FLUSH, rand_pix());
        sent++;
      end
      if ($urandom_range(0, 4) == 0) push_item(ACT_FLUSH, rand_pix());
    end
    settle();
  endtask

  // Driver: the predictor advances on every accepted transfer.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      clear_prediction();
    end else begin
      if (cfg_wen) apply_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) predict_blur(s_tuser, s_tdata);
      if (!s_tvalid || s_tready) begin
        if (pixel_feed.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          nxt = pixel_feed.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= nxt.action;
          s_tdata <= nxt.pixel;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    if (!rst && m_tvalid && m_tready) begin
      if (blur_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual blurred=%0d frame_end=%0b",
                 $time, m_tdata, m_tlast);
        mismatches++;
      end else begin
        want = blur_due.pop_front();
        if (m_tdata !== want.blurred) begin
          $display("%0t: blurred mismatch, expected %0d, actual %0d",
                   $time, want.blurred, m_tdata);
          mismatches++;
        end
        if (m_tlast !== want.frame_end) begin
          $display("%0t: frame_end mismatch, expected %0b, actual %0b",
                   $time, want.frame_end, m_tlast);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned phase, w, h, total, npix, r;
    bit need_cfg;
    logic [FRAME_WIDTH_W-1:0] wv;
    logic [FRAME_HEIGHT_W-1:0] hv;
    need_cfg = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset sizes: a flush with nothing to drain, then two pixels with no result.
    push_item(ACT_FLUSH, 8'hA5);
    push_item(ACT_PIXEL, 8'hFF);
    push_item(ACT_PIXEL, 8'h00);
    settle();

    // Zero sizes act as a single pixel; a pixel during the drain is dropped.
    write_reg(REG_WIDTH, 16'h0000);
    write_reg(REG_HEIGHT, 16'h0000);
    push_item(ACT_PIXEL, 8'd200);
    push_item(ACT_PIXEL, 8'd7);
    push_item(ACT_FLUSH, 8'h5A);
    push_item(ACT_FLUSH, 8'hFF);
    settle();

    // Checkerboard 3x3 with writes to unused indexes in the middle of the frame.
    write_reg(REG_WIDTH, 16'hF803);
    write_reg(REG_HEIGHT, 16'd3);
    for (int i = 0; i < 5; i++) push_item(ACT_PIXEL, (i % 2) ? 8'h00 : 8'hFF);
    settle();
    write_reg(REG_SPARE_A, 16'hFFFF);
    write_reg(REG_SPARE_B, 16'h0000);
    for (int i = 5; i < 9; i++) push_item(ACT_PIXEL, (i % 2) ? 8'h00 : 8'hFF);
    for (int i = 0; i < 4; i++) push_item(ACT_FLUSH, 8'h00);
    settle();

    // A single column, where only two pixels are averaged.
    write_reg(REG_WIDTH, 16'd1);
    write_reg(REG_HEIGHT, 16'd2);
    push_item(ACT_PIXEL, 8'd255);
    push_item(ACT_PIXEL, 8'd254);
    push_item(ACT_FLUSH, 8'h0F);
    push_item(ACT_FLUSH, 8'hF0);
    settle();

    for (phase = 0; sent < 1550; phase++) begin
      steady = (phase >= 12 && phase < 24);
      if (phase == 3) begin
        // Widest frame and tallest frame, abandoned early.
        write_reg(REG_WIDTH, 16'd1024);
        write_reg(REG_HEIGHT, 16'hFFFF);
        feed_frame(60);
        need_cfg = 1'b1;
      end else if (phase == 7) begin
        write_reg(REG_WIDTH, 16'hF802);
        write_reg(REG_HEIGHT, 16'hFFFF);
        feed_frame(120);
        need_cfg = 1'b1;
      end else begin
        if (need_cfg || $urandom_range(0, 9) < 7) begin
          r = $urandom_range(0, 19);
          w = (r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 2 :
              (r == 3) ? $urandom_range(13, 40) : $urandom_range(1, 12);
          r = $urandom_range(0, 9);
          h = (r == 0) ? 0 : (r == 1) ? 1 : $urandom_range(1, 6);
          wv = 11'(w);
          hv = 16'(h);
          if ($urandom_range(0, 7) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
          case ($urandom_range(0, 3))
            0: write_reg(REG_WIDTH, {5'($urandom), wv});
            1: write_reg(REG_HEIGHT, hv);
            2: begin
              write_reg(REG_HEIGHT, hv);
              write_reg(REG_WIDTH, {5'($urandom), wv});
            end
            default: begin
              write_reg(REG_WIDTH, {5'($urandom), wv});
              write_reg(REG_HEIGHT, hv);
            end
          endcase
          need_cfg = 1'b0;
        end
        total = eff_cols(gen_w) * eff_rows(gen_h);
        if (total > 240 || $urandom_range(0, 6) == 0) begin
          // The next register write abandons this frame part way.
          npix = $urandom_range(0, (total - 1 < 150) ? total - 1 : 150);
          need_cfg = 1'b1;
        end else begin
          npix = total;
        end
        feed_frame(npix);
      end
    end
    steady = 1'b0;

    // A frame at the saturated width, abandoned part way along its only row.
    write_reg(REG_WIDTH, 16'hFFFF);
    write_reg(REG_HEIGHT, 16'd1);
    feed_frame(200);

    repeat (16) @(posedge clk);
    if (mismatches == 0 && blur_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
